FILE: hw/rtl/sphinv_pkg.sv
`timescale 1ns / 1ps

package sphinv_pkg;

    // Coordinate format; results in raw units do not depend on the fraction width.
    localparam int FRAC_BITS   = 16;
    localparam int CW          = 32;
    localparam int NCOORD      = 3;

    // Configuration port.
    localparam int CFG_IDX_W   = 3;
    localparam int RAD_W       = 31;
    localparam int TOL_W       = 16;
    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1) << FRAC_BITS;
    localparam logic [TOL_W-1:0] TOL_RESET    = TOL_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd4;

    // Datapath widths.
    localparam int OFF_W       = CW + 1;
    localparam int MAG_W       = CW;
    localparam int R2_W        = 2 * RAD_W;
    localparam int R2_LO_W     = 32;
    localparam int R2_HI_W     = R2_W - R2_LO_W;
    localparam int SQ_W        = 2 * MAG_W + 2;
    localparam int RM_W        = R2_W + MAG_W;
    localparam int NUM_W       = RM_W + 2;
    localparam int DEN_W       = SQ_W + 1;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int SQRT_REM_W  = ROOT_W + 2;
    localparam int SQRT_DIGITS = ROOT_W;
    localparam int Q_W         = 33;
    localparam int DREM_W      = DEN_W + Q_W;
    localparam int SUM_W       = Q_W + 2;

    // Both arithmetic units have this many register stages.
    localparam int UNIT_LAT    = SQRT_DIGITS + 1;

    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_INV    = 2'd0,
        ST_ON     = 2'd1,
        ST_CENTER = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    // Item data that rides beside the arithmetic units.
    typedef struct packed {
        logic [NCOORD-1:0][CW-1:0] pt;
        logic [NCOORD-1:0]         neg;
        logic                      szero;
    } t_side;

    typedef struct packed {
        logic [NCOORD-1:0][CW-1:0] img;
        t_status                   status;
    } t_result;

endpackage

FILE: hw/rtl/sphinv_sqrt.sv
`timescale 1ns / 1ps

module sphinv_sqrt (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [sphinv_pkg::SQ_W-1:0]        i_rad,
    input  logic [sphinv_pkg::RAD_W-1:0]       i_radius,
    input  logic [sphinv_pkg::TOL_W-1:0]       i_tol,
    output logic                               o_on
);

    logic [sphinv_pkg::SQ_W-1:0]       r_rad  [sphinv_pkg::SQRT_DIGITS];
    logic [sphinv_pkg::SQRT_REM_W-1:0] r_rem  [sphinv_pkg::SQRT_DIGITS];
    logic [sphinv_pkg::ROOT_W-1:0]     r_root [sphinv_pkg::SQRT_DIGITS];
    logic                              r_on;

    // One root bit per stage: two radicand bits are brought down each time.
    for (genvar k = 0; k < sphinv_pkg::SQRT_DIGITS; k++) begin : g_digit
        logic [sphinv_pkg::SQ_W-1:0]         w_rad;
        logic [sphinv_pkg::SQRT_REM_W-1:0]   w_rem;
        logic [sphinv_pkg::ROOT_W-1:0]       w_root;
        logic [sphinv_pkg::SQRT_REM_W+1:0]   w_cur;
        logic [sphinv_pkg::SQRT_REM_W+1:0]   w_trial;
        logic [sphinv_pkg::SQRT_REM_W+1:0]   w_diff;

        if (k == 0) begin : g_in
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_mid
            assign w_rad  = r_rad[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        assign w_cur   = {w_rem, w_rad[sphinv_pkg::SQ_W-1 -: 2]};
        assign w_trial = {{(sphinv_pkg::SQRT_REM_W - sphinv_pkg::ROOT_W){1'b0}}, w_root, 2'b01};
        assign w_diff  = w_cur - w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k] <= w_rad << 2;
                if (w_cur >= w_trial) begin
                    r_rem[k]  <= w_diff[sphinv_pkg::SQRT_REM_W-1:0];
                    r_root[k] <= {w_root[sphinv_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cur[sphinv_pkg::SQRT_REM_W-1:0];
                    r_root[k] <= {w_root[sphinv_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    logic [sphinv_pkg::ROOT_W:0] w_a;
    logic [sphinv_pkg::ROOT_W:0] w_b;
    logic [sphinv_pkg::ROOT_W:0] w_dist;

    assign w_a    = {1'b0, r_root[sphinv_pkg::SQRT_DIGITS-1]};
    assign w_b    = (sphinv_pkg::ROOT_W + 1)'(i_radius);
    assign w_dist = (w_a > w_b) ? (w_a - w_b) : (w_b - w_a);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_on <= w_dist < (sphinv_pkg::ROOT_W + 1)'(i_tol);
        end
    end

    assign o_on = r_on;

endmodule

FILE: hw/rtl/sphinv_div.sv
`timescale 1ns / 1ps

module sphinv_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sphinv_pkg::NUM_W-1:0]  i_num,
    input  logic [sphinv_pkg::DEN_W-1:0]  i_den,
    output logic [sphinv_pkg::Q_W-1:0]    o_quo,
    output logic                          o_ovf
);

    logic [sphinv_pkg::DREM_W-1:0] r_rem [sphinv_pkg::Q_W+1];
    logic [sphinv_pkg::DEN_W-1:0]  r_den [sphinv_pkg::Q_W+1];
    logic [sphinv_pkg::Q_W-1:0]    r_q   [sphinv_pkg::Q_W+1];
    logic                          r_ovf [sphinv_pkg::Q_W+1];

    // First stage: a quotient that does not fit in Q_W bits saturates the image anyway.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= sphinv_pkg::DREM_W'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= sphinv_pkg::DREM_W'(i_num) >= {i_den, {sphinv_pkg::Q_W{1'b0}}};
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar j = 1; j <= sphinv_pkg::Q_W; j++) begin : g_bit
        localparam int B = sphinv_pkg::Q_W - j;
        logic [sphinv_pkg::DREM_W-1:0] w_t;

        assign w_t = {{sphinv_pkg::Q_W{1'b0}}, r_den[j-1]} << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j] <= r_den[j-1];
                r_ovf[j] <= r_ovf[j-1];
                if (r_rem[j-1] >= w_t) begin
                    r_rem[j] <= r_rem[j-1] - w_t;
                    r_q[j]   <= {r_q[j-1][sphinv_pkg::Q_W-2:0], 1'b1};
                end else begin
                    r_rem[j] <= r_rem[j-1];
                    r_q[j]   <= {r_q[j-1][sphinv_pkg::Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_q[sphinv_pkg::Q_W];
    assign o_ovf = r_ovf[sphinv_pkg::Q_W];

endmodule

FILE: hw/rtl/sphere_inversion_3d.sv
// Throughput: one request per cycle while o_in_stall is low; 34 of the pipeline stages are
// the bit-per-stage square root and the three bit-per-stage dividers that run side by side.
// An output stall freezes the pipeline once the one-entry skid register behind it is full.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps

module sphere_inversion_3d (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sphinv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sphinv_pkg::CW-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [sphinv_pkg::CW-1:0]     i_point_x,
    input  logic signed [sphinv_pkg::CW-1:0]     i_point_y,
    input  logic signed [sphinv_pkg::CW-1:0]     i_point_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [sphinv_pkg::CW-1:0]     o_image_x,
    output logic signed [sphinv_pkg::CW-1:0]     o_image_y,
    output logic signed [sphinv_pkg::CW-1:0]     o_image_z,
    output logic [1:0]                           o_status
);

    localparam int CW = sphinv_pkg::CW;
    localparam int NC = sphinv_pkg::NCOORD;

    // Configuration registers.
    logic [CW-1:0]                     r_center [NC];
    logic [sphinv_pkg::RAD_W-1:0]      r_radius;
    logic [sphinv_pkg::TOL_W-1:0]      r_tol;
    logic [sphinv_pkg::R2_W-1:0]       r_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NC; i++) begin
                r_center[i] <= '0;
            end
            r_radius <= sphinv_pkg::RADIUS_RESET;
            r_tol    <= sphinv_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sphinv_pkg::CFG_CENTER_X: r_center[0] <= i_cfg_data;
                sphinv_pkg::CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                sphinv_pkg::CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                sphinv_pkg::CFG_RADIUS:   r_radius    <= i_cfg_data[sphinv_pkg::RAD_W-1:0];
                sphinv_pkg::CFG_TOL:      r_tol       <= i_cfg_data[sphinv_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // The squared radius is registered; it follows the radius register in the next cycle.
    always_ff @(posedge i_clk) begin
        r_r2 <= r_radius * r_radius;
    end

    logic w_adv;
    logic r_skid_valid;
    assign w_adv      = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    logic [NC-1:0][CW-1:0] w_pt_in;
    assign w_pt_in[0] = i_point_x;
    assign w_pt_in[1] = i_point_y;
    assign w_pt_in[2] = i_point_z;

    // Stage 0: offset from the center.
    logic                                   r0_v;
    logic [NC-1:0][CW-1:0]                  r0_pt;
    logic [NC-1:0][sphinv_pkg::OFF_W-1:0]   r0_off;
    // Stage 1: magnitude and sign.
    logic                                   r1_v;
    logic [NC-1:0][CW-1:0]                  r1_pt;
    logic [NC-1:0][sphinv_pkg::MAG_W-1:0]   r1_mag;
    logic [NC-1:0]                          r1_neg;
    // Stage 2: products.
    logic                                   r2_v;
    logic [NC-1:0][CW-1:0]                  r2_pt;
    logic [NC-1:0]                          r2_neg;
    logic [NC-1:0][2*sphinv_pkg::MAG_W-1:0] r2_sq;
    logic [NC-1:0][sphinv_pkg::MAG_W+sphinv_pkg::R2_LO_W-1:0] r2_plo;
    logic [NC-1:0][sphinv_pkg::MAG_W+sphinv_pkg::R2_HI_W-1:0] r2_phi;
    // Stage 3: squared distance and R^2 * |offset|.
    logic                                   r3_v;
    logic [NC-1:0][CW-1:0]                  r3_pt;
    logic [NC-1:0]                          r3_neg;
    logic [sphinv_pkg::SQ_W-1:0]            r3_s;
    logic [NC-1:0][sphinv_pkg::RM_W-1:0]    r3_rm;
    // Stage 4: rounded numerators and common denominator.
    logic                                   r4_v;
    sphinv_pkg::t_side                      r4_side;
    logic [sphinv_pkg::SQ_W-1:0]            r4_s;
    logic [NC-1:0][sphinv_pkg::NUM_W-1:0]   r4_num;
    logic [sphinv_pkg::DEN_W-1:0]           r4_den;

    logic [sphinv_pkg::OFF_W-1:0] w_abs [NC];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            w_abs[i] = r0_off[i][sphinv_pkg::OFF_W-1] ? (sphinv_pkg::OFF_W'(0) - r0_off[i])
                                                      : r0_off[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r0_v <= i_in_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NC; i++) begin
                r0_pt[i]  <= w_pt_in[i];
                r0_off[i] <= {w_pt_in[i][CW-1], w_pt_in[i]} - {r_center[i][CW-1], r_center[i]};

                r1_pt[i]  <= r0_pt[i];
                r1_mag[i] <= w_abs[i][sphinv_pkg::MAG_W-1:0];
                r1_neg[i] <= r0_off[i][sphinv_pkg::OFF_W-1];

                r2_pt[i]  <= r1_pt[i];
                r2_neg[i] <= r1_neg[i];
                r2_sq[i]  <= r1_mag[i] * r1_mag[i];
                r2_plo[i] <= r1_mag[i] * r_r2[sphinv_pkg::R2_LO_W-1:0];
                r2_phi[i] <= r1_mag[i] * r_r2[sphinv_pkg::R2_W-1:sphinv_pkg::R2_LO_W];

                r3_pt[i]  <= r2_pt[i];
                r3_neg[i] <= r2_neg[i];
                r3_rm[i]  <= {r2_phi[i], {sphinv_pkg::R2_LO_W{1'b0}}}
                             + sphinv_pkg::RM_W'(r2_plo[i]);

                // 2*R^2*|o| + S over 2*S gives R^2*|o|/S rounded half away from zero.
                r4_num[i] <= sphinv_pkg::NUM_W'({r3_rm[i], 1'b0})
                             + sphinv_pkg::NUM_W'(r3_s);
                r4_side.pt[i]  <= r3_pt[i];
                r4_side.neg[i] <= r3_neg[i];
            end
            r3_s          <= sphinv_pkg::SQ_W'(r2_sq[0]) + sphinv_pkg::SQ_W'(r2_sq[1])
                             + sphinv_pkg::SQ_W'(r2_sq[2]);
            r4_s          <= r3_s;
            r4_den        <= {r3_s, 1'b0};
            r4_side.szero <= (r3_s == '0);
        end
    end

    // Arithmetic units.
    logic                                w_on;
    logic [NC-1:0][sphinv_pkg::Q_W-1:0]  w_quo;
    logic [NC-1:0]                       w_ovf;

    sphinv_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_rad    (r4_s),
        .i_radius (r_radius),
        .i_tol    (r_tol),
        .o_on     (w_on)
    );

    for (genvar g = 0; g < NC; g++) begin : g_div
        sphinv_div u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (r4_num[g]),
            .i_den (r4_den),
            .o_quo (w_quo[g]),
            .o_ovf (w_ovf[g])
        );
    end

    // Item data delayed to line up with the unit outputs.
    logic              r_dv   [sphinv_pkg::UNIT_LAT];
    sphinv_pkg::t_side r_side [sphinv_pkg::UNIT_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sphinv_pkg::UNIT_LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_dv[0] <= r4_v;
            for (int k = 1; k < sphinv_pkg::UNIT_LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= r4_side;
            for (int k = 1; k < sphinv_pkg::UNIT_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Final combine: center plus signed quotient, clamped to the coordinate range; ON and CENTER keep the point.
    sphinv_pkg::t_side            w_side;
    sphinv_pkg::t_result          w_res;
    logic [sphinv_pkg::SUM_W-1:0] w_ext_c [NC];
    logic [sphinv_pkg::SUM_W-1:0] w_ext_q [NC];
    logic [sphinv_pkg::SUM_W-1:0] w_sum   [NC];
    logic [NC-1:0]                w_sat_hi;
    logic [NC-1:0]                w_sat_lo;
    logic [NC-1:0][CW-1:0]        w_val;

    assign w_side = r_side[sphinv_pkg::UNIT_LAT-1];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            w_ext_c[i] = {{(sphinv_pkg::SUM_W-CW){r_center[i][CW-1]}}, r_center[i]};
            w_ext_q[i] = {2'b00, w_quo[i]};
            w_sum[i]   = w_side.neg[i] ? (w_ext_c[i] - w_ext_q[i]) : (w_ext_c[i] + w_ext_q[i]);
            w_sat_hi[i] = (w_ovf[i] && !w_side.neg[i])
                          || (!w_sum[i][sphinv_pkg::SUM_W-1]
                              && w_sum[i][sphinv_pkg::SUM_W-2:CW-1] != '0);
            w_sat_lo[i] = (w_ovf[i] && w_side.neg[i])
                          || (w_sum[i][sphinv_pkg::SUM_W-1]
                              && w_sum[i][sphinv_pkg::SUM_W-2:CW-1] != '1);
            if (w_sat_hi[i]) begin
                w_val[i] = sphinv_pkg::COORD_MAX;
            end else if (w_sat_lo[i]) begin
                w_val[i] = sphinv_pkg::COORD_MIN;
            end else begin
                w_val[i] = w_sum[i][CW-1:0];
            end
        end

        if (w_on) begin
            w_res.img    = w_side.pt;
            w_res.status = sphinv_pkg::ST_ON;
        end else if (w_side.szero) begin
            w_res.img    = w_side.pt;
            w_res.status = sphinv_pkg::ST_CENTER;
        end else if ((w_sat_hi | w_sat_lo) != '0) begin
            w_res.img    = w_val;
            w_res.status = sphinv_pkg::ST_SAT;
        end else begin
            w_res.img    = w_val;
            w_res.status = sphinv_pkg::ST_INV;
        end
    end

    // Output register with a one-entry skid register behind it.
    logic                r_out_valid;
    sphinv_pkg::t_result r_out;
    sphinv_pkg::t_result r_skid;
    logic                w_up_valid;

    assign w_up_valid = r_dv[sphinv_pkg::UNIT_LAT-1] && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_up_valid;
            end
        end else if (w_up_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_up_valid) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_image_x   = r_out.img[0];
    assign o_image_y   = r_out.img[1];
    assign o_image_z   = r_out.img[2];
    assign o_status    = r_out.status;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid register filled without a stalled output");

    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == sphinv_pkg::ST_SAT) |->
            (o_image_x == sphinv_pkg::COORD_MAX || o_image_x == sphinv_pkg::COORD_MIN ||
             o_image_y == sphinv_pkg::COORD_MAX || o_image_y == sphinv_pkg::COORD_MIN ||
             o_image_z == sphinv_pkg::COORD_MAX || o_image_z == sphinv_pkg::COORD_MIN))
        else $error("saturated status without any coordinate at a bound");
`endif

endmodule

FILE: dv/tb_sphere_inversion_3d.sv
`timescale 1ns / 1ps

module tb_sphere_inversion_3d;

    typedef logic [sphinv_pkg::NCOORD-1:0][sphinv_pkg::CW-1:0] t_point;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [sphinv_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [sphinv_pkg::CW-1:0]        i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic signed [sphinv_pkg::CW-1:0] i_point_x, i_point_y, i_point_z;
    logic                             o_out_valid;
    logic                             i_out_stall;
    logic signed [sphinv_pkg::CW-1:0] o_image_x, o_image_y, o_image_z;
    logic [1:0]                       o_status;

    sphere_inversion_3d i_dut (.*);

    // Sphere settings as the block should hold them.
    logic [sphinv_pkg::CW-1:0]    sph_center [sphinv_pkg::NCOORD];
    logic [sphinv_pkg::RAD_W-1:0] sph_radius;
    logic [sphinv_pkg::TOL_W-1:0] sph_tol;

    t_point              point_queue [$];
    sphinv_pkg::t_result image_queue [$];
    int                  fail_count;
    int                  idle_cycles;
    int                  in_gap;
    int                  out_gap;
    bit                  calm_in;
    bit                  calm_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic sphinv_pkg::t_result invert_point(t_point pt);
        sphinv_pkg::t_result res;
        longint       off [sphinv_pkg::NCOORD];
        logic [63:0]  mag [sphinv_pkg::NCOORD];
        logic [127:0] s, num, q;
        logic [63:0]  d, cand, diff, r2, qm;
        longint       v;
        s = '0;
        for (int i = 0; i < sphinv_pkg::NCOORD; i++) begin
            off[i] = longint'($signed(pt[i])) - longint'($signed(sph_center[i]));
            mag[i] = off[i] < 0 ? -off[i] : off[i];
            s += 128'(mag[i]) * 128'(mag[i]);
        end
        d = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = d | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= s) d = cand;
        end
        diff = d > sph_radius ? d - sph_radius : sph_radius - d;
        if (diff < sph_tol || s == 0) begin
            res.img = pt;
            res.status = diff < sph_tol ? sphinv_pkg::ST_ON : sphinv_pkg::ST_CENTER;
            return res;
        end
        res.status = sphinv_pkg::ST_INV;
        r2 = 64'(sph_radius) * 64'(sph_radius);
        for (int i = 0; i < sphinv_pkg::NCOORD; i++) begin
            num = ((128'(r2) * 128'(mag[i])) << 1) + s;
            q = num / (s << 1);
            qm = q > (128'd1 << 40) ? (64'd1 << 40) : q[63:0];
            v = longint'($signed(sph_center[i])) + (off[i] < 0 ? -longint'(qm) : longint'(qm));
            if (v > 64'sh7FFF_FFFF) begin
                v = 64'sh7FFF_FFFF;
                res.status = sphinv_pkg::ST_SAT;
            end
            if (v < -64'sh8000_0000) begin
                v = -64'sh8000_0000;
                res.status = sphinv_pkg::ST_SAT;
            end
            res.img[i] = v[sphinv_pkg::CW-1:0];
        end
        return res;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Request side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) image_queue.push_back(invert_point({i_point_z, i_point_y, i_point_x}));
            if ($urandom_range(0, 63) == 0) calm_in = ~calm_in;
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (point_queue.size() > 0) begin
                t_point p;
                p = point_queue.pop_front();
                i_in_valid <= 1'b1;
                i_point_x <= p[0];
                i_point_y <= p[1];
                i_point_z <= p[2];
                in_gap <= calm_in ? 0 : draw_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (image_queue.size() == 0) begin
                    $error("unexpected result %h %h %h", o_image_x, o_image_y, o_image_z);
                    fail_count++;
                end else begin
                    sphinv_pkg::t_result e;
                    e = image_queue.pop_front();
                    if (o_image_x !== e.img[0]) begin
                        $error("image_x expected %h actual %h", e.img[0], o_image_x);
                        fail_count++;
                    end
                    if (o_image_y !== e.img[1]) begin
                        $error("image_y expected %h actual %h", e.img[1], o_image_y);
                        fail_count++;
                    end
                    if (o_image_z !== e.img[2]) begin
                        $error("image_z expected %h actual %h", e.img[2], o_image_z);
                        fail_count++;
                    end
                    if (o_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, o_status);
                        fail_count++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) calm_out = ~calm_out;
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!calm_out) out_gap <= draw_gap();
            end
        end
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("[sphere_inversion_3d] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [sphinv_pkg::CFG_IDX_W-1:0] idx,
                             logic [sphinv_pkg::CW-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            sphinv_pkg::CFG_CENTER_X: sph_center[0] = data;
            sphinv_pkg::CFG_CENTER_Y: sph_center[1] = data;
            sphinv_pkg::CFG_CENTER_Z: sph_center[2] = data;
            sphinv_pkg::CFG_RADIUS:   sph_radius = data[sphinv_pkg::RAD_W-1:0];
            sphinv_pkg::CFG_TOL:      sph_tol = data[sphinv_pkg::TOL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_sphere(logic [sphinv_pkg::CW-1:0] cx, logic [sphinv_pkg::CW-1:0] cy,
                              logic [sphinv_pkg::CW-1:0] cz, logic [sphinv_pkg::CW-1:0] rad,
                              logic [sphinv_pkg::CW-1:0] tol);
        write_reg(sphinv_pkg::CFG_CENTER_X, cx);
        write_reg(sphinv_pkg::CFG_CENTER_Y, cy);
        write_reg(sphinv_pkg::CFG_CENTER_Z, cz);
        write_reg(sphinv_pkg::CFG_RADIUS, rad);
        write_reg(sphinv_pkg::CFG_TOL, tol);
    endtask

    task automatic add_point(longint x, longint y, longint z);
        t_point p;
        p[0] = x[sphinv_pkg::CW-1:0];
        p[1] = y[sphinv_pkg::CW-1:0];
        p[2] = z[sphinv_pkg::CW-1:0];
        point_queue.push_back(p);
    endtask

    // Mix of arbitrary points, points near the center and points near the surface.
    task automatic add_random_points(int n);
        longint cx, cy, cz, dlt;
        for (int k = 0; k < n; k++) begin
            cx = longint'($signed(sph_center[0]));
            cy = longint'($signed(sph_center[1]));
            cz = longint'($signed(sph_center[2]));
            case ($urandom_range(0, 3))
                0: add_point($urandom, $urandom, $urandom);
                1: add_point(cx + $signed(16'($urandom)), cy + $signed(16'($urandom)),
                             cz + $signed(16'($urandom)));
                2: begin
                    dlt = longint'(sph_radius) + $signed(4'($urandom));
                    case ($urandom_range(0, 2))
                        0: add_point(cx - dlt, cy, cz);
                        1: add_point(cx, cy + dlt, cz);
                        default: add_point(cx, cy, cz - dlt);
                    endcase
                end
                default: add_point(cx + $signed(24'($urandom)), cy + $signed(24'($urandom)),
                                   cz + $signed(24'($urandom)));
            endcase
        end
    endtask

    task automatic drain();
        while (point_queue.size() > 0 || image_queue.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    initial begin
        fail_count = 0;
        calm_in = 1'b0;
        calm_out = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_z = '0;
        sph_center = '{default: '0};
        sph_radius = sphinv_pkg::RADIUS_RESET;
        sph_tol = sphinv_pkg::TOL_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: unit sphere at the origin.
        add_point(0, 0, 0);
        add_point(65536, 0, 0);
        add_point(0, -65536, 0);
        add_point(131072, 0, 0);
        add_point(1, 0, 0);
        add_point(0, -1, 0);
        add_point(0, 0, 1);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000);
        add_point(65535, 0, 0);
        add_random_points(60);
        drain();

        // Zero tolerance: a point on the sphere is inverted onto itself.
        set_sphere(0, 0, 0, 32'h0001_0000, 0);
        add_point(65536, 0, 0);
        add_point(0, 0, 0);
        add_random_points(60);
        drain();

        // Zero radius, with junk in the upper register bits and unused indexes.
        set_sphere(32'h0010_0000, 32'hFFF0_0000, 5, 32'h8000_0000, 32'hFFFF_0000);
        write_reg(3'd5, $urandom);
        write_reg(3'd7, $urandom);
        add_point(0, 0, 0);
        add_point(32'h0010_0000, -64'sh0010_0000, 5);
        add_random_points(60);
        drain();

        // Extreme center, largest radius, largest tolerance.
        set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF);
        add_point(-64'sh8000_0000, 32'h7FFF_FFFF, -64'sh8000_0000);
        add_point(32'h7FFF_FFFF, -64'sh8000_0000, 32'h7FFF_FFFF);
        add_random_points(60);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_sphere($urandom, $urandom, $urandom,
                       ph[0] ? $urandom_range(0, 32'h0100_0000) : $urandom,
                       ph[1] ? $urandom_range(0, 16) : $urandom);
            add_random_points(45);
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && image_queue.size() == 0) begin
            $display("[sphere_inversion_3d] OK");
        end else begin
            $display("[sphere_inversion_3d] ERROR");
        end
        $finish;
    end

endmodule
